@@ design/spindle_speed_ramp_pwm_core_macros.svh @@
// Assertion shorthands used by the spindle ramp controller.
`ifndef SPINDLE_SPEED_RAMP_PWM_CORE_MACROS_SVH
`define SPINDLE_SPEED_RAMP_PWM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ssr_pkg.sv @@
package ssr_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_SPEED     = 3'd0;
    localparam logic [2:0] REG_MIN_SPEED     = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP     = 3'd2;
    localparam logic [2:0] REG_RAMP_INTERVAL = 3'd3;
    localparam logic [2:0] REG_MAX_DUTY      = 3'd4;

    localparam logic [15:0] MAX_SPEED_RST     = 16'd30000;
    localparam logic [15:0] MIN_SPEED_RST     = 16'd0;
    localparam logic [15:0] RAMP_STEP_RST     = 16'd1000;
    localparam logic [15:0] RAMP_INTERVAL_RST = 16'd1000;
    localparam logic [7:0]  MAX_DUTY_RST      = 8'd255;

    // rpm * 255 is 24 bits wide: one quotient bit per divider step
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic load_in;    // capture the input item
        logic setup;      // clamp goal, count down wait, or stop
        logic ramp;       // take a ramp step if due
        logic div_load;   // seed the divider from the current rpm
        logic div_step;   // one restoring divider step
        logic duty_wr;    // cap the quotient and write the duty
        logic out_load;   // move the result into the output register
    } ssr_cmd_t;

    typedef struct packed {
        logic ramp_move;  // the pending ramp step changes the speed
        logic out_busy;   // output register holds an item not yet taken
    } ssr_stat_t;

endpackage

@@ design/spindle_speed_ramp_pwm_core.sv @@
// Spindle speed ramp with PWM duty output; one result item per input item.
// An accepted item passes the setup and ramp states and goes to emit when the speed holds still;
// when a ramp step changes the speed, the 24-step serial divider first recomputes the duty.
// No new item is taken until the last result has moved into the output register.
// Reset (aresetn, synchronous, active low) loads register defaults and zeroes goal, speed,
// wait and duty; the block is ready for an item in the first cycle after reset.
module spindle_speed_ramp_pwm_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_rpm_request,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_duty,
    output logic [15:0] m_speed_now,
    output logic [15:0] m_speed_goal,
    output logic        m_at_goal
);
    import ssr_pkg::*;

    ssr_cmd_t  cmd;
    ssr_stat_t stat;

    // Sequence each item: capture, setup (clamp, count down, stop), ramp step,
    // optional duty division, then hand the result to the output register.
    ssr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold configuration, ramp state, the serial divider and the output register.
    // The output register parts the two sides, so the next item is taken while
    // a finished result still waits for m_ready.
    ssr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_func        (s_func),
        .s_rpm_request (s_rpm_request),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_speed_now   (m_speed_now),
        .m_speed_goal  (m_speed_goal),
        .m_at_goal     (m_at_goal)
    );

endmodule

@@ design/ssr_ctrl.sv @@
`include "spindle_speed_ramp_pwm_core_macros.svh"

module ssr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssr_pkg::ssr_stat_t stat,
    output ssr_pkg::ssr_cmd_t  cmd
);
    import ssr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RAMP,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DUTY,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                state_next = ST_RAMP;
            end
            ST_RAMP: begin
                state_next = stat.ramp_move ? ST_DIV_LOAD : ST_EMIT;
            end
            ST_DIV_LOAD: begin
                cnt_next   = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) state_next = ST_DUTY;
            end
            ST_DUTY: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && s_valid;
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.ramp     = (state_reg == ST_RAMP);
        cmd.div_load = (state_reg == ST_DIV_LOAD);
        cmd.div_step = (state_reg == ST_DIV_RUN);
        cmd.duty_wr  = (state_reg == ST_DUTY);
        cmd.out_load = (state_reg == ST_EMIT) && !stat.out_busy;
    end

    `SSR_ASSERT_NXT(a_accept_setup, aclk, aresetn, s_valid && s_ready, state_reg == ST_SETUP, "accepted item did not enter setup")
    `SSR_ASSERT_NXT(a_div_len, aclk, aresetn, state_reg == ST_DIV_RUN && cnt_reg == DIV_LAST, state_reg == ST_DUTY, "divider did not finish after its last step")
    `SSR_ASSERT_NXT(a_emit_idle, aclk, aresetn, state_reg == ST_EMIT && !stat.out_busy, state_reg == ST_IDLE, "result emitted but controller not idle")
    `SSR_ASSERT_IMP(a_div_cnt, aclk, aresetn, state_reg == ST_DIV_RUN, cnt_reg <= DIV_LAST, "divider step count out of range")

endmodule

@@ design/ssr_dp.sv @@
module ssr_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssr_pkg::ssr_cmd_t  cmd,
    output ssr_pkg::ssr_stat_t stat,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         s_func,
    input  logic [15:0]        s_rpm_request,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_duty,
    output logic [15:0]        m_speed_now,
    output logic [15:0]        m_speed_goal,
    output logic               m_at_goal
);
    import ssr_pkg::*;

    logic [15:0] max_speed_reg, min_speed_reg, ramp_step_reg, ramp_interval_reg;
    logic [7:0]  max_duty_reg;

    logic [1:0]  func_reg;
    logic [15:0] req_reg;

    logic [15:0] goal_reg, cur_reg, wait_reg;
    logic [7:0]  duty_reg;

    logic [15:0]          rem_reg;
    logic [DIV_STEPS-1:0] qd_reg;
    logic                 m_valid_reg;

    logic [15:0] req_cap, goal_clamped, wait_dec, ramp_diff, cur_stepped, cur_ramped;
    logic        ramp_due;
    logic [16:0] trial;
    logic        trial_ge;
    logic [DIV_STEPS-1:0] dividend;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg     <= MAX_SPEED_RST;
            min_speed_reg     <= MIN_SPEED_RST;
            ramp_step_reg     <= RAMP_STEP_RST;
            ramp_interval_reg <= RAMP_INTERVAL_RST;
            max_duty_reg      <= MAX_DUTY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_SPEED:     max_speed_reg     <= cfg_data;
                REG_MIN_SPEED:     min_speed_reg     <= cfg_data;
                REG_RAMP_STEP:     ramp_step_reg     <= cfg_data;
                REG_RAMP_INTERVAL: ramp_interval_reg <= cfg_data;
                REG_MAX_DUTY:      max_duty_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Clamp to the maximum first, then raise a nonzero request to the minimum
    always_comb begin
        req_cap      = (req_reg > max_speed_reg) ? max_speed_reg : req_reg;
        goal_clamped = (req_cap != 16'd0 && req_cap < min_speed_reg) ? min_speed_reg : req_cap;
        wait_dec     = (wait_reg != 16'd0) ? wait_reg - 16'd1 : 16'd0;
    end

    // Ramp step: fall to the goal at once, rise by at most ramp_step
    always_comb begin
        ramp_diff   = goal_reg - cur_reg;
        cur_stepped = cur_reg + ramp_step_reg;
        if (goal_reg < cur_reg) begin
            cur_ramped = goal_reg;
        end else begin
            cur_ramped = (ramp_diff > ramp_step_reg) ? cur_stepped : goal_reg;
        end
        ramp_due = (func_reg == FUNC_SET) ||
                   ((func_reg == FUNC_TICK) && (wait_reg == 16'd0));
    end

    assign stat.ramp_move = ramp_due && (goal_reg != cur_reg);
    assign stat.out_busy  = m_valid_reg && !m_ready;

    // Restoring division of rpm*255 by max_speed
    always_comb begin
        dividend = {cur_reg, 8'd0} - {8'd0, cur_reg};
        trial    = {rem_reg, qd_reg[DIV_STEPS-1]};
        trial_ge = (trial >= {1'b0, max_speed_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg <= '0;
            cur_reg  <= '0;
            wait_reg <= '0;
            duty_reg <= '0;
        end else begin
            if (cmd.setup) begin
                case (func_reg)
                    FUNC_TICK: wait_reg <= wait_dec;
                    FUNC_SET:  goal_reg <= goal_clamped;
                    FUNC_STOP: begin
                        goal_reg <= '0;
                        cur_reg  <= '0;
                        wait_reg <= '0;
                        duty_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.ramp) begin
                if (func_reg == FUNC_TICK && stat.ramp_move) wait_reg <= ramp_interval_reg;
                if (stat.ramp_move) cur_reg <= cur_ramped;
            end
            if (cmd.duty_wr) begin
                if (cur_reg == 16'd0) begin
                    duty_reg <= '0;
                end else if (qd_reg > DIV_STEPS'(max_duty_reg)) begin
                    duty_reg <= max_duty_reg;
                end else begin
                    duty_reg <= qd_reg[7:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= s_func;
            req_reg  <= s_rpm_request;
        end
        if (cmd.div_load) begin
            rem_reg <= '0;
            qd_reg  <= dividend;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? 16'(trial - {1'b0, max_speed_reg}) : trial[15:0];
            qd_reg  <= {qd_reg[DIV_STEPS-2:0], trial_ge};
        end
        if (cmd.out_load) begin
            m_duty       <= duty_reg;
            m_speed_now  <= cur_reg;
            m_speed_goal <= goal_reg;
            m_at_goal    <= (cur_reg == goal_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ sim/spindle_ramp_checker.sv @@
module spindle_ramp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_rpm_request,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_duty,
    input  logic [15:0] m_speed_now,
    input  logic [15:0] m_speed_goal,
    input  logic        m_at_goal,
    output int          mismatches,
    output int          pending,
    output int          compared
);
    import ssr_pkg::*;

    typedef struct packed {
        logic [7:0]  duty;
        logic [15:0] speed_now;
        logic [15:0] speed_goal;
        logic        at_goal;
    } spindle_report_t;

    // Register copies
    logic [15:0] top_rpm;
    logic [15:0] floor_rpm;
    logic [15:0] step_rpm;
    logic [15:0] interval_ms;
    logic [7:0]  duty_cap;

    // Predicted spindle state
    logic [15:0] goal_rpm_q;
    logic [15:0] speed_rpm_q;
    logic [15:0] wait_ms_q;
    logic [7:0]  duty_q;

    spindle_report_t due_reports[$];
    int bad_count  = 0;
    int seen_count = 0;

    // Full-scale duty, truncated; a zero divisor saturates any nonzero rpm.
    function automatic logic [7:0] duty_for(input logic [15:0] rpm);
        logic [31:0] quot;
        if (top_rpm == '0)
            quot = (rpm == '0) ? 32'd0 : '1;
        else
            quot = (32'(rpm) * 32'd255) / 32'(top_rpm);
        if (quot > 32'(duty_cap))
            quot = 32'(duty_cap);
        return quot[7:0];
    endfunction

    // Drop straight to the goal, or climb by at most one step.
    function automatic void ramp_speed();
        if (goal_rpm_q < speed_rpm_q) begin
            speed_rpm_q = goal_rpm_q;
            duty_q      = duty_for(speed_rpm_q);
        end else if (goal_rpm_q > speed_rpm_q) begin
            if (goal_rpm_q - speed_rpm_q > step_rpm)
                speed_rpm_q = speed_rpm_q + step_rpm;
            else
                speed_rpm_q = goal_rpm_q;
            duty_q = duty_for(speed_rpm_q);
        end
    endfunction

    function automatic spindle_report_t apply_item(input logic [1:0] func,
                                                   input logic [15:0] req);
        logic [15:0] want_rpm;
        want_rpm = req;
        case (func)
            FUNC_TICK: begin
                if (wait_ms_q != '0)
                    wait_ms_q = wait_ms_q - 16'd1;
                if (goal_rpm_q != speed_rpm_q && wait_ms_q == '0) begin
                    wait_ms_q = interval_ms;
                    ramp_speed();
                end
            end
            FUNC_SET: begin
                if (want_rpm > top_rpm)
                    want_rpm = top_rpm;
                if (want_rpm != '0 && want_rpm < floor_rpm)
                    want_rpm = floor_rpm;
                goal_rpm_q = want_rpm;
                ramp_speed();
            end
            FUNC_STOP: begin
                goal_rpm_q  = '0;
                speed_rpm_q = '0;
                wait_ms_q   = '0;
                duty_q      = '0;
            end
            default: begin
            end
        endcase
        return '{duty: duty_q, speed_now: speed_rpm_q, speed_goal: goal_rpm_q,
                 at_goal: (speed_rpm_q == goal_rpm_q)};
    endfunction

    always @(posedge aclk) begin
        spindle_report_t want;
        spindle_report_t got;
        if (!aresetn) begin
            top_rpm     = MAX_SPEED_RST;
            floor_rpm   = MIN_SPEED_RST;
            step_rpm    = RAMP_STEP_RST;
            interval_ms = RAMP_INTERVAL_RST;
            duty_cap    = MAX_DUTY_RST;
            goal_rpm_q  = '0;
            speed_rpm_q = '0;
            wait_ms_q   = '0;
            duty_q      = '0;
            due_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_SPEED:     top_rpm     = cfg_data;
                    REG_MIN_SPEED:     floor_rpm   = cfg_data;
                    REG_RAMP_STEP:     step_rpm    = cfg_data;
                    REG_RAMP_INTERVAL: interval_ms = cfg_data;
                    REG_MAX_DUTY:      duty_cap    = cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            // Retire before predicting: a result never leaves in its own acceptance cycle.
            if (m_valid && m_ready) begin
                got = {m_duty, m_speed_now, m_speed_goal, m_at_goal};
                if (due_reports.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("[%0t] result with nothing outstanding: duty %0d now %0d goal %0d at %0b",
                                 $time, got.duty, got.speed_now, got.speed_goal, got.at_goal);
                end else begin
                    want = due_reports.pop_front();
                    seen_count++;
                    if (got !== want) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("[%0t] result mismatch (expected/actual): duty %0d/%0d",
                                     $time, want.duty, got.duty);
                            $display("    now %0d/%0d goal %0d/%0d at %0b/%0b",
                                     want.speed_now, got.speed_now, want.speed_goal,
                                     got.speed_goal, want.at_goal, got.at_goal);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                due_reports.push_back(apply_item(s_func, s_rpm_request));
        end
        mismatches <= bad_count;
        pending    <= due_reports.size();
        compared   <= seen_count;
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import ssr_pkg::*;

    // Spare function code: the block must ignore it and report unchanged state.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int CALM_PHASE      = 4;    // no idling on either side
    localparam int HOLD_PHASE      = 6;    // receiver backs off for a long stretch
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 40;   // longer than the slowest item through the divider

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func        = FUNC_TICK;
    logic [15:0] s_rpm_request = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_duty;
    logic [15:0] m_speed_now;
    logic [15:0] m_speed_goal;
    logic        m_at_goal;

    int mismatches;
    int pending;
    int compared;

    // Stimulus bookkeeping
    logic        calm      = 1'b0;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          items_sent    = 0;
    int          settings_used = 0;
    logic [15:0] cur_top   = MAX_SPEED_RST;

    spindle_speed_ramp_pwm_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_rpm_request (s_rpm_request),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_speed_now   (m_speed_now),
        .m_speed_goal  (m_speed_goal),
        .m_at_goal     (m_at_goal)
    );

    spindle_ramp_checker ramp_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_rpm_request (s_rpm_request),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty        (m_duty),
        .m_speed_now   (m_speed_now),
        .m_speed_goal  (m_speed_goal),
        .m_at_goal     (m_at_goal),
        .mismatches    (mismatches),
        .pending       (pending),
        .compared      (compared)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("spindle_speed_ramp_pwm_core verification failed");
        $finish;
    end

    // Receiver: drop ready about 23 times in a hundred, never while calm; once per run
    // hold ready low for a long stretch so the result register fills and s_ready falls.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Offer one item, idling first at random; valid stays high from one item to the
    // next when there is no gap, so it is never lowered and raised in the same step.
    task automatic send_item(input logic [1:0] func, input logic [15:0] req);
        while (!calm && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_rpm_request <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // Hold the input idle until every outstanding result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
    endtask

    // Write all five registers, one per cycle; only called with the block idle.
    task automatic program_regs(input logic [15:0] top, input logic [15:0] floor,
                                input logic [15:0] step, input logic [15:0] interval,
                                input logic [7:0] cap);
        logic [15:0] word [5];
        word[REG_MAX_SPEED]     = top;
        word[REG_MIN_SPEED]     = floor;
        word[REG_RAMP_STEP]     = step;
        word[REG_RAMP_INTERVAL] = interval;
        // Upper byte is don't-care for the duty cap; toggle it anyway.
        word[REG_MAX_DUTY]      = {8'($urandom), cap};
        for (int i = 0; i <= int'(REG_MAX_DUTY); i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= word[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cur_top   = top;
        settings_used++;
    endtask

    // Random settings, weighted towards the edges: unit and full-scale speed, floor
    // above ceiling, zero and huge steps, every-tick and very slow intervals.
    task automatic program_random();
        logic [15:0] top;
        logic [15:0] floor;
        logic [15:0] step;
        logic [15:0] interval;
        logic [7:0]  cap;
        int          roll;
        roll = $urandom_range(99);
        top  = (roll < 10) ? 16'd1 : (roll < 25) ? 16'hFFFF :
               (roll < 60) ? 16'($urandom_range(2000, 50)) : 16'($urandom_range(65535, 1));
        roll  = $urandom_range(99);
        floor = (roll < 35) ? 16'd0 : (roll < 45) ? 16'hFFFF :
                (roll < 55) ? 16'($urandom) : 16'($urandom_range(int'(top)));
        roll = $urandom_range(99);
        step = (roll < 10) ? 16'd0 : (roll < 20) ? 16'hFFFF :
               (roll < 30) ? 16'($urandom) : 16'($urandom_range(int'(top) / 4 + 1, 1));
        roll     = $urandom_range(99);
        interval = (roll < 20) ? 16'd0 : (roll < 70) ? 16'($urandom_range(5, 1)) :
                   (roll < 92) ? 16'($urandom_range(50, 6)) : 16'hFFFF;
        roll = $urandom_range(99);
        cap  = (roll < 10) ? 8'd0 : (roll < 40) ? 8'hFF : 8'($urandom);
        program_regs(top, floor, step, interval, cap);
    endtask

    // Mostly ticks so the ramp gets to run; sets aim inside the current range with
    // some full-range and small requests; stops and spare codes as noise.
    task automatic pick_item(output logic [1:0] func, output logic [15:0] req);
        int roll;
        roll = $urandom_range(99);
        req  = 16'($urandom);
        if (roll < 68) begin
            func = FUNC_TICK;
        end else if (roll < 88) begin
            func = FUNC_SET;
            case ($urandom_range(3))
                0, 1: req = 16'($urandom_range(int'(cur_top)));
                2:    req = 16'($urandom_range(255));
                default: begin
                end
            endcase
        end else if (roll < 94) begin
            func = FUNC_STOP;
        end else begin
            func = FUNC_SPARE;
        end
    endtask

    initial begin : stimulus
        logic [1:0]  func;
        logic [15:0] req;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: clamp of a full-scale request, first timed step, spare code,
        // drop to zero, stop.
        send_item(FUNC_SET, 16'hFFFF);
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_SPARE, 16'hA5A5);
        send_item(FUNC_SET, 16'h0000);
        send_item(FUNC_STOP, 16'h5A5A);

        // Small request raised to the floor, stepped climb, countdown between steps,
        // immediate drop to a lower goal.
        drain_results();
        program_regs(16'd1000, 16'd200, 16'd300, 16'd2, 8'd200);
        send_item(FUNC_SET, 16'd50);
        send_item(FUNC_SET, 16'd900);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_SET, 16'd100);
        send_item(FUNC_STOP, 16'd0);

        // Floor above ceiling: goal overshoots max_speed and the duty saturates at the cap.
        drain_results();
        program_regs(16'd100, 16'd500, 16'hFFFF, 16'd0, 8'd180);
        send_item(FUNC_SET, 16'd10);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_SET, 16'hFFFF);

        // Zero ramp step: a rising goal never moves, with a zero duty cap.
        drain_results();
        program_regs(16'd40000, 16'd0, 16'd0, 16'hFFFF, 8'd0);
        send_item(FUNC_SET, 16'd1000);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);

        // Zero max_speed: every request clamps to zero.
        drain_results();
        program_regs(16'd0, 16'd7, 16'hFFFF, 16'd0, 8'd99);
        send_item(FUNC_SET, 16'd5);
        send_item(FUNC_TICK, 16'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            if (phase == 0)
                program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 8'hFF);
            else if (phase == 1)
                program_regs(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 8'd0);
            else
                program_random();
            calm <= (phase == CALM_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == HOLD_PHASE && n == 40)
                    hold_req <= 1'b1;
                pick_item(func, req);
                send_item(func, req);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Drove %0d items across %0d register settings; %0d results compared.",
                 items_sent, settings_used, compared);
        $display("Included one %0d-cycle receiver hold-off with the sender still offering.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("spindle_speed_ramp_pwm_core verification clean");
        else
            $display("spindle_speed_ramp_pwm_core verification failed");
        $finish;
    end

endmodule
